// ===== design/dvrt_pkg.sv =====
`default_nettype none

package dvrt_pkg;

	// default sizes of the table and the hop limit
	localparam int NODE_COUNT_DEF = 16;
	localparam int HOP_LIMIT_DEF  = 16;

	// widest table index (covers up to 64 entries)
	localparam int IX_W = 6;

	// depth of the queues between front, back and result port
	localparam int CMD_Q_DEPTH = 2;
	localparam int RES_Q_DEPTH = 2;

	// cost codes
	localparam logic [7:0] COST_INF = 8'd255;
	localparam logic [8:0] COST_MAX = 9'd254;

	// operation codes
	localparam logic [2:0] OP_BEACON = 3'd0;
	localparam logic [2:0] OP_AGE    = 3'd1;
	localparam logic [2:0] OP_CARGO  = 3'd2;
	localparam logic [2:0] OP_REPORT = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	// action codes
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_DELIVER = 3'd1;
	localparam logic [2:0] ACT_FORWARD = 3'd2;
	localparam logic [2:0] ACT_DROP    = 3'd3;
	localparam logic [2:0] ACT_REPORT  = 3'd4;

	// configuration registers
	localparam int         CFG_DATA_W  = 16;
	localparam logic       REG_OWN_ID  = 1'b0;
	localparam logic       REG_TIMEOUT = 1'b1;
	localparam logic [4:0] OWN_ID_RST  = 5'd1;
	localparam logic [15:0] TIMEOUT_RST = 16'd10;

	// RSSI thresholds in dBm and the link penalties they select
	localparam logic signed [7:0] RSSI_GOOD = -8'sd55;
	localparam logic signed [7:0] RSSI_FAIR = -8'sd70;
	localparam logic signed [7:0] RSSI_POOR = -8'sd85;
	localparam logic [7:0] PEN_GOOD = 8'd1;
	localparam logic [7:0] PEN_FAIR = 8'd4;
	localparam logic [7:0] PEN_POOR = 8'd15;
	localparam logic [7:0] PEN_BAD  = 8'd50;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [2:0]      op;
		logic [4:0]      nb;
		logic [IX_W-1:0] nb_ix;
		logic [IX_W-1:0] ix;
		logic            ix_ok;
		logic            do_refresh;
		logic            do_relax;
		logic [7:0]      pen;
		logic [7:0]      prop;
		logic [31:0]     now;
		logic            own_dest;
		logic            room;
		logic [4:0]      hop_next;
		logic [4:0]      hop_sat;
		logic            label_match;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic [2:0] action;
		logic       send_valid;
		logic [7:0] send_to;
		logic [4:0] hop_count_out;
		logic       append_own_id;
		logic       label_match;
		logic [7:0] cost_read;
	} res_t;

	// map beacon RSSI to a link penalty
	function automatic logic [7:0] penalty_of_rssi(input logic signed [7:0] rssi);
		logic [7:0] pen;
		if (rssi >= RSSI_GOOD) begin
			pen = PEN_GOOD;
		end else if (rssi >= RSSI_FAIR) begin
			pen = PEN_FAIR;
		end else if (rssi >= RSSI_POOR) begin
			pen = PEN_POOR;
		end else begin
			pen = PEN_BAD;
		end
		return pen;
	endfunction

endpackage

`default_nettype wire

// ===== design/dvrt_fifo.sv =====
`default_nettype none

module dvrt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT) else $error("queue fill count above its depth");
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty)) else $error("queue flagged full and empty at once");
`endif

endmodule

`default_nettype wire

// ===== design/dvrt_front.sv =====
`default_nettype none

module dvrt_front import dvrt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int HOP_LIMIT  = HOP_LIMIT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [2:0]        operation,
	input  wire logic [4:0]        src_node,
	input  wire logic signed [7:0] link_rssi,
	input  wire logic [3:0]        entry_index,
	input  wire logic [7:0]        adv_cost,
	input  wire logic              beacon_first,
	input  wire logic [31:0]       now_seconds,
	input  wire logic [4:0]        final_destination,
	input  wire logic [4:0]        hop_count_in,
	input  wire logic [7:0]        actual_label,
	input  wire logic [7:0]        chosen_label,
	input  wire logic [4:0]        own_id,
	input  wire logic              cmd_pop,
	output logic                   cmd_empty,
	output cmd_t                   cmd
);

	localparam logic [7:0] NODES8 = 8'(NODE_COUNT);
	localparam logic [7:0] HOPS8  = 8'(HOP_LIMIT);

	logic [7:0] nb8;
	logic [7:0] own8;
	logic [7:0] idx8;
	logic [7:0] dest8;
	logic       nb_ok;
	logic       own_ok;
	logic       idx_ok;
	logic       dest_ok;
	logic       nb_own;
	logic       idx_own;
	logic [8:0] sum;
	cmd_t       cmd_in;
	logic [$bits(cmd_t)-1:0] q_rdata;

	// range checks on the ids of the item
	assign nb8     = {3'b0, src_node};
	assign own8    = {3'b0, own_id};
	assign idx8    = {4'b0, entry_index};
	assign dest8   = {3'b0, final_destination};
	assign nb_ok   = (nb8 != 8'd0) && (nb8 <= NODES8);
	assign own_ok  = (own8 != 8'd0) && (own8 <= NODES8);
	assign idx_ok  = idx8 < NODES8;
	assign dest_ok = (dest8 != 8'd0) && (dest8 <= NODES8);
	assign nb_own  = own_ok && (nb8 == own8);
	assign idx_own = own_ok && (idx8 == own8 - 8'd1);

	// classify the item
	always_comb begin
		cmd_in            = '0;
		cmd_in.op         = operation;
		cmd_in.nb         = src_node;
		cmd_in.nb_ix      = IX_W'(nb8 - 8'd1);
		cmd_in.pen        = penalty_of_rssi(link_rssi);
		sum               = {1'b0, adv_cost} + {1'b0, cmd_in.pen};
		cmd_in.prop       = (sum > COST_MAX) ? COST_INF : sum[7:0];
		cmd_in.now        = now_seconds;
		cmd_in.do_refresh = nb_ok && !nb_own && beacon_first;
		cmd_in.do_relax   = nb_ok && !nb_own && idx_ok && !idx_own &&
			(adv_cost != COST_INF);
		if (operation == OP_CARGO) begin
			cmd_in.ix    = IX_W'(dest8 - 8'd1);
			cmd_in.ix_ok = dest_ok;
		end else begin
			cmd_in.ix    = IX_W'(idx8);
			cmd_in.ix_ok = idx_ok;
		end
		cmd_in.own_dest    = (final_destination == own_id);
		cmd_in.room        = {3'b0, hop_count_in} < HOPS8;
		cmd_in.hop_next    = hop_count_in + 5'd1;
		cmd_in.hop_sat     = cmd_in.room ? hop_count_in : HOPS8[4:0];
		cmd_in.label_match = (actual_label == chosen_label);
	end

	// queue toward the back end
	dvrt_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_Q_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (q_rdata),
		.empty  (cmd_empty)
	);

	assign cmd = cmd_t'(q_rdata);

endmodule

`default_nettype wire

// ===== design/dvrt_back.sv =====
`default_nettype none

module dvrt_back import dvrt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic [4:0]                 own_id,
	input  wire logic                  cmd_empty,
	input  wire cmd_t                  cmd,
	output logic                       cmd_pop,
	input  wire logic                  res_full,
	output logic                       res_push,
	output res_t                       res
);

	localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IX    = IDX_W'(NODE_COUNT - 1);
	localparam logic [IDX_W-1:0] OWN_RST_IX = IDX_W'(int'(OWN_ID_RST) - 1);
	localparam logic [7:0]       NODES8     = 8'(NODE_COUNT);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_REFRESH = 3'd1;
	localparam logic [2:0] ST_RELAX   = 3'd2;
	localparam logic [2:0] ST_AGE     = 3'd3;
	localparam logic [2:0] ST_LOOK    = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [2:0]       state_q;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] age_cnt_q;
	res_t             res_q;
	logic [4:0]       own_q;
	logic [15:0]      tmo_q;
	logic [7:0]       cost_q [NODE_COUNT];
	logic [7:0]       nh_q   [NODE_COUNT];
	logic [31:0]      seen_q [NODE_COUNT];

	logic             start;
	logic [7:0]       own8;
	logic             own_ok;
	logic [IDX_W-1:0] own_ix;
	logic [7:0]       cfg_own8;
	logic             cfg_own_ok;
	logic [IDX_W-1:0] cfg_own_ix;
	logic [IDX_W-1:0] nb_ix;
	logic [IDX_W-1:0] rd_ix;
	logic [7:0]       rd_cost;
	logic [7:0]       rd_nh;
	logic [31:0]      rd_seen;
	logic [7:0]       home;
	logic             home_ok;
	logic [7:0]       nh_dest;
	logic             better;
	logic             via_nb;
	logic [31:0]      age;
	logic             age_skip;
	logic             stale;
	res_t             look_res;

	assign cfg_ready = 1'b1;
	assign own_id    = own_q;
	assign res       = res_q;

	// own entry position, now and for a pending write
	assign own8       = {3'b0, own_q};
	assign own_ok     = (own8 != 8'd0) && (own8 <= NODES8);
	assign own_ix     = IDX_W'(own8 - 8'd1);
	assign cfg_own8   = {3'b0, cfg_data[4:0]};
	assign cfg_own_ok = (cfg_own8 != 8'd0) && (cfg_own8 <= NODES8);
	assign cfg_own_ix = IDX_W'(cfg_own8 - 8'd1);

	// start a new word once the previous result is handed on
	assign start    = (state_q == ST_IDLE) || ((state_q == ST_DONE) && !res_full);
	assign cmd_pop  = start && !cmd_empty;
	assign res_push = (state_q == ST_DONE) && !res_full;

	// table read port, beside a fixed read of entry 0 for the home next hop
	assign nb_ix   = cmd_q.nb_ix[IDX_W-1:0];
	assign rd_ix   = (state_q == ST_AGE) ? age_cnt_q : cmd_q.ix[IDX_W-1:0];
	assign rd_cost = cost_q[rd_ix];
	assign rd_nh   = nh_q[rd_ix];
	assign rd_seen = seen_q[rd_ix];
	assign home    = nh_q[0];
	assign home_ok = (home != COST_INF);

	// relaxation and aging decisions
	assign better   = cmd_q.prop < rd_cost;
	assign via_nb   = (rd_nh == {3'b0, cmd_q.nb});
	assign age      = cmd_q.now - rd_seen;
	assign stale    = age > {16'b0, tmo_q};
	assign age_skip = (own_ok && (age_cnt_q == own_ix)) || (rd_cost == COST_INF);
	assign nh_dest  = cmd_q.ix_ok ? rd_nh : COST_INF;

	// cargo, report and read results
	always_comb begin
		look_res = '0;
		case (cmd_q.op)
			OP_CARGO: begin
				if (cmd_q.own_dest) begin
					look_res.action        = ACT_DELIVER;
					look_res.append_own_id = cmd_q.room;
					look_res.hop_count_out = cmd_q.room ? cmd_q.hop_next : cmd_q.hop_sat;
					look_res.label_match   = cmd_q.label_match;
					look_res.send_valid    = home_ok;
					look_res.send_to       = home_ok ? home : 8'd0;
				end else if ((nh_dest != COST_INF) && cmd_q.room) begin
					look_res.action        = ACT_FORWARD;
					look_res.append_own_id = 1'b1;
					look_res.hop_count_out = cmd_q.hop_next;
					look_res.send_valid    = 1'b1;
					look_res.send_to       = nh_dest;
				end else begin
					look_res.action        = ACT_DROP;
					look_res.hop_count_out = cmd_q.hop_sat;
					look_res.send_valid    = home_ok;
					look_res.send_to       = home_ok ? home : 8'd0;
				end
			end
			OP_REPORT: begin
				if (home_ok) begin
					look_res.action     = ACT_REPORT;
					look_res.send_valid = 1'b1;
					look_res.send_to    = home;
				end
			end
			OP_READ: begin
				look_res.cost_read = cmd_q.ix_ok ? rd_cost : COST_INF;
			end
			default: begin
				look_res = '0;
			end
		endcase
	end

	// sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= '0;
			age_cnt_q <= '0;
			res_q     <= '0;
			own_q     <= OWN_ID_RST;
			tmo_q     <= TIMEOUT_RST;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_DONE: begin
					if (start) begin
						if (!cmd_empty) begin
							cmd_q <= cmd;
							res_q <= '0;
							if (cmd.op == OP_BEACON) begin
								state_q <= cmd.do_refresh ? ST_REFRESH : ST_RELAX;
							end else if (cmd.op == OP_AGE) begin
								state_q <= ST_AGE;
							end else begin
								state_q <= ST_LOOK;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_REFRESH: begin
					state_q <= ST_RELAX;
				end
				ST_RELAX: begin
					state_q <= ST_DONE;
				end
				ST_AGE: begin
					if (age_cnt_q == LAST_IX) begin
						age_cnt_q <= '0;
						state_q   <= ST_DONE;
					end else begin
						age_cnt_q <= age_cnt_q + 1'b1;
					end
				end
				ST_LOOK: begin
					res_q   <= look_res;
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_OWN_ID:  own_q <= cfg_data[4:0];
					REG_TIMEOUT: tmo_q <= cfg_data;
					default:     tmo_q <= tmo_q;
				endcase
			end
		end
	end

	// route table: sequencer updates plus own-entry writes from configuration, which pin the own entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				cost_q[i] <= (IDX_W'(i) == OWN_RST_IX) ? 8'd0 : COST_INF;
				nh_q[i]   <= (IDX_W'(i) == OWN_RST_IX) ? {3'b0, OWN_ID_RST} : COST_INF;
				seen_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_REFRESH) begin
				cost_q[nb_ix] <= cmd_q.pen;
				nh_q[nb_ix]   <= {3'b0, cmd_q.nb};
				seen_q[nb_ix] <= cmd_q.now;
			end
			if ((state_q == ST_RELAX) && cmd_q.do_relax) begin
				if (better) begin
					cost_q[rd_ix] <= cmd_q.prop;
					nh_q[rd_ix]   <= {3'b0, cmd_q.nb};
					seen_q[rd_ix] <= cmd_q.now;
				end else if (via_nb) begin
					cost_q[rd_ix] <= cmd_q.prop;
					seen_q[rd_ix] <= cmd_q.now;
				end
			end
			if ((state_q == ST_AGE) && !age_skip && stale) begin
				cost_q[rd_ix] <= COST_INF;
			end
			if (cfg_valid && (cfg_index == REG_OWN_ID) && cfg_own_ok) begin
				cost_q[cfg_own_ix] <= 8'd0;
				nh_q[cfg_own_ix]   <= cfg_own8;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_own_entry: assert property (@(posedge clk) disable iff (!arst_n)
		own_ok |-> (cost_q[own_ix] == 8'd0) && (nh_q[own_ix] == own8))
		else $error("own route entry lost cost zero or its own next hop");
	a_age_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_AGE) |-> (age_cnt_q == '0))
		else $error("aging counter left nonzero outside the aging walk");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q != ST_IDLE) && (state_q != ST_DONE))
		else $error("word taken from the queue without starting work");
`endif

endmodule

`default_nettype wire

// ===== design/distance_vector_route_table.sv =====
// Distance-vector route table of one mesh node.
// Input channel: a word is taken on a clock edge with push high and full low.
// It carries one operation: beacon entry, table aging, cargo routing, report
// passing or cost read. Result channel: while empty is low the oldest result
// sits on the result ports; pop with empty low takes it. Every input word
// gives exactly one result word, in order.
// Configuration: cfg_valid/cfg_ready write own_node_id (index 0) and
// stale_timeout_seconds (index 1); write only while no word is in flight.
// Sequencing: a front queue of two words holds classified items, the back end
// runs them one at a time. Cargo, report and read pass a lookup state, a beacon
// a refresh state (only when refreshing) and a relax state, and aging walks all
// NODE_COUNT entries (one table entry a cycle); each ends in a done state.
// Reset: all costs and next hops become 255, timestamps zero, own id 1 with
// its entry at cost 0 and next hop 1; usable once reset is released.
// A stalled receiver fills the two-word result queue, then the back end
// holds, then the command queue fills and full rises.
`default_nettype none

module distance_vector_route_table import dvrt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int HOP_LIMIT  = HOP_LIMIT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [2:0]            operation,
	input  wire logic [4:0]            src_node,
	input  wire logic signed [7:0]     link_rssi,
	input  wire logic [3:0]            entry_index,
	input  wire logic [7:0]            adv_cost,
	input  wire logic                  beacon_first,
	input  wire logic [31:0]           now_seconds,
	input  wire logic [4:0]            final_destination,
	input  wire logic [4:0]            hop_count_in,
	input  wire logic [7:0]            actual_label,
	input  wire logic [7:0]            chosen_label,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [2:0]                 action,
	output logic                       send_valid,
	output logic [7:0]                 send_to,
	output logic [4:0]                 hop_count_out,
	output logic                       append_own_id,
	output logic                       label_match,
	output logic [7:0]                 cost_read,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [4:0] own_id;
	logic       cmd_pop;
	logic       cmd_empty;
	cmd_t       cmd;
	logic       res_full;
	logic       res_push;
	res_t       res;
	logic [$bits(res_t)-1:0] res_rdata;
	res_t       res_out;

	// accept and classify
	dvrt_front #(
		.NODE_COUNT (NODE_COUNT),
		.HOP_LIMIT  (HOP_LIMIT)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.operation         (operation),
		.src_node          (src_node),
		.link_rssi         (link_rssi),
		.entry_index       (entry_index),
		.adv_cost          (adv_cost),
		.beacon_first      (beacon_first),
		.now_seconds       (now_seconds),
		.final_destination (final_destination),
		.hop_count_in      (hop_count_in),
		.actual_label      (actual_label),
		.chosen_label      (chosen_label),
		.own_id            (own_id),
		.cmd_pop           (cmd_pop),
		.cmd_empty         (cmd_empty),
		.cmd               (cmd)
	);

	// table and sequencer
	dvrt_back #(
		.NODE_COUNT (NODE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.own_id    (own_id),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue toward the receiver
	dvrt_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out       = res_t'(res_rdata);
	assign action        = res_out.action;
	assign send_valid    = res_out.send_valid;
	assign send_to       = res_out.send_to;
	assign hop_count_out = res_out.hop_count_out;
	assign append_own_id = res_out.append_own_id;
	assign label_match   = res_out.label_match;
	assign cost_read     = res_out.cost_read;

endmodule

`default_nettype wire
